@@ hdl/ial_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ial_pkg
// Shared types and codes for the indexed array list: request and result
// words, action and status codes, list sizing.
// ---------------------------------------------------------------------------
package ial_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 5;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // width wide enough to compare a request index against the count
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_AT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_VAL = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [POS_W-1:0]         position;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
    } rsp_t;

endpackage
`default_nettype wire

@@ hdl/ial_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ial_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module ial_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/indexed_array_list.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// indexed_array_list
// Fixed-capacity ordered list of signed words: read, append, insert,
// remove-at and remove-by-value, one word of result per request.
// ---------------------------------------------------------------------------
// Append, insert at the tail, rejected and unknown requests finish straight
//   from idle; read waits on the registered RAM read; remove-at reads the word,
//   then moves any later entries down; insert moves entries up, then writes;
//   remove-by-value scans from the head, then moves entries as remove-at does.
// Throughput: one request at a time; busy drops as the strobe rises.
//   The receiver cannot stall. Reset clears the count and control state, not the stored words.
module indexed_array_list
    import ial_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      done,
    output rsp_t      rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [2:0]          state_reg, state_next;
    logic [ACTION_W-1:0] op_reg, op_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   src_reg, src_next;
    logic [ADDR_W-1:0]   end_reg, end_next;
    logic [ADDR_W-1:0]   wdst_reg, wdst_next;
    logic                grow_reg, grow_next;
    logic                more_reg, more_next;
    logic                pend_reg, pend_next;
    logic [CNT_W-1:0]    cptr_reg, cptr_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    rsp_t                rsp_reg, rsp_next;
    logic                done_reg, done_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic [DATA_W-1:0]   fin_data;
    logic [POS_W-1:0]    fin_pos;
    logic [CNT_W-1:0]    fin_cnt;

    ial_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        src_next   = src_reg;
        end_next   = end_reg;
        wdst_next  = wdst_reg;
        grow_next  = grow_reg;
        more_next  = more_reg;
        pend_next  = pend_reg;
        cptr_next  = cptr_reg;
        data_next  = data_reg;
        pos_next   = pos_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = val_reg;
        ram_re    = 1'b0;
        ram_raddr = '0;

        fin        = 1'b0;
        fin_status = ST_OK;
        fin_data   = '0;
        fin_pos    = '0;
        fin_cnt    = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = req.action;
                    idx_next = req.index;
                    val_next = req.value;
                    unique case (req.action) inside
                        ACT_READ, ACT_REMOVE_AT:
                        begin
                            if (CMP_W'(req.index) < CMP_W'(cnt_reg))
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ADDR_W'(req.index);
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                fin_status = ST_RANGE;
                            end
                        end
                        ACT_APPEND:
                        begin
                            fin = 1'b1;
                            if (cnt_reg < CAP_CNT)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(cnt_reg);
                                ram_wdata = req.value;
                                fin_cnt   = cnt_reg + 1'b1;
                            end
                            else
                            begin
                                fin_status = ST_FULL;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (CMP_W'(req.index) > CMP_W'(cnt_reg))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_RANGE;
                            end
                            else if (cnt_reg == CAP_CNT)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else if (CMP_W'(req.index) == CMP_W'(cnt_reg))
                            begin
                                fin       = 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(req.index);
                                ram_wdata = req.value;
                                fin_cnt   = cnt_reg + 1'b1;
                            end
                            else
                            begin
                                // open a gap: move entries up from the tail
                                src_next   = ADDR_W'(cnt_reg - 1'b1);
                                end_next   = ADDR_W'(req.index);
                                grow_next  = 1'b1;
                                more_next  = 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_MOVE;
                            end
                        end
                        ACT_REMOVE_VAL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                cptr_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                data_next = ram_rdata;
                pos_next  = '0;
                if (op_reg == ACT_READ)
                begin
                    fin      = 1'b1;
                    fin_data = ram_rdata;
                end
                else if (CMP_W'(idx_reg) + 1'b1 < CMP_W'(cnt_reg))
                begin
                    src_next   = ADDR_W'(idx_reg) + 1'b1;
                    end_next   = ADDR_W'(cnt_reg - 1'b1);
                    grow_next  = 1'b0;
                    more_next  = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_MOVE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                if (ram_rdata == val_reg)
                begin
                    data_next = ram_rdata;
                    pos_next  = POS_W'(cptr_reg);
                    if (cptr_reg + 1'b1 < cnt_reg)
                    begin
                        src_next   = ADDR_W'(cptr_reg + 1'b1);
                        end_next   = ADDR_W'(cnt_reg - 1'b1);
                        grow_next  = 1'b0;
                        more_next  = 1'b1;
                        pend_next  = 1'b0;
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (cptr_reg + 1'b1 == cnt_reg)
                begin
                    fin        = 1'b1;
                    fin_status = ST_NOT_FOUND;
                end
                else
                begin
                    // advance: fetch the next entry while comparing this one
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(cptr_reg + 1'b1);
                    cptr_next = cptr_reg + 1'b1;
                end
            end
            S_MOVE:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wdst_reg;
                    ram_wdata = ram_rdata;
                end
                if (more_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = src_reg;
                    pend_next = 1'b1;
                    wdst_next = grow_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                    if (src_reg == end_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        src_next = grow_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                fin = 1'b1;
                if (op_reg == ACT_INSERT)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(idx_reg);
                    ram_wdata = val_reg;
                    fin_cnt   = cnt_reg + 1'b1;
                end
                else
                begin
                    fin_cnt  = cnt_reg - 1'b1;
                    fin_data = data_reg;
                    fin_pos  = pos_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            cnt_next          = fin_cnt;
            rsp_next.data_out = fin_data;
            rsp_next.position = fin_pos;
            rsp_next.status   = fin_status;
            rsp_next.count    = COUNT_W'(fin_cnt);
            done_next         = 1'b1;
            state_next        = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            more_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            more_reg  <= more_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        src_reg  <= src_next;
        end_reg  <= end_next;
        wdst_reg <= wdst_next;
        grow_reg <= grow_next;
        cptr_reg <= cptr_next;
        data_reg <= data_next;
        pos_reg  <= pos_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result strobe without a request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FULL) |-> (rsp.count == COUNT_W'(CAPACITY)))
        else $error("full status with list not full");

    a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> (cnt_reg != '0))
        else $error("entry move on an empty list");

endmodule
`default_nettype wire

@@ test/indexed_array_list_test.sv @@
// ---------------------------------------------------------------------------
// indexed_array_list_test
// Self-checking bench for the indexed array list. A driver sends request
// words in random bursts from a queue filled at start-up: a directed opener
// covering the range, full, miss and unknown-action cases, then random
// grow/shrink traffic. A monitor predicts every accepted request with its
// own copy of the list and checks each result word field by field.
// ---------------------------------------------------------------------------
module indexed_array_list_test;
    import ial_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh80000000;
    localparam int RANDOM_REQS = 1150;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        req_t word;
        bit   hold_for_drain;
    } queued_req_t;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    queued_req_t              requests_to_send[$];
    rsp_t                     list_results_due[$];
    logic signed [DATA_W-1:0] stim_list[$];    // list contents as the stimulus sees them

    // predicted list state
    logic signed [DATA_W-1:0] model_words[CAPACITY];
    int                       model_len = 0;

    bit hs_seen = 1'b0;
    int gap_left = 0;
    int burst_left = 0;
    int accepted_reqs = 0;
    int total_reqs = 0;
    int errors = 0;
    int cycles = 0;

    indexed_array_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic void model_take_out(int at);
        for (int k = at + 1; k < model_len; k++)
        begin
            model_words[k - 1] = model_words[k];
        end
        model_len--;
    endfunction

    function automatic rsp_t list_apply(req_t r);
        rsp_t o;
        int   idx;
        int   hit;
        o   = '0;
        idx = int'(r.index);
        hit = -1;
        case (r.action)
            ACT_READ:
            begin
                if (idx < model_len)
                    o.data_out = model_words[idx];
                else
                    o.status = ST_RANGE;
            end
            ACT_APPEND:
            begin
                if (model_len < CAPACITY)
                begin
                    model_words[model_len] = r.value;
                    model_len++;
                end
                else
                    o.status = ST_FULL;
            end
            ACT_INSERT:
            begin
                // range check wins over the full check
                if (idx > model_len)
                    o.status = ST_RANGE;
                else if (model_len >= CAPACITY)
                    o.status = ST_FULL;
                else
                begin
                    for (int k = model_len; k > idx; k--)
                    begin
                        model_words[k] = model_words[k - 1];
                    end
                    model_words[idx] = r.value;
                    model_len++;
                end
            end
            ACT_REMOVE_AT:
            begin
                if (idx < model_len)
                begin
                    o.data_out = model_words[idx];
                    model_take_out(idx);
                end
                else
                    o.status = ST_RANGE;
            end
            ACT_REMOVE_VAL:
            begin
                for (int k = 0; k < model_len && hit < 0; k++)
                begin
                    if (model_words[k] == r.value)
                        hit = k;
                end
                if (hit >= 0)
                begin
                    o.data_out = model_words[hit];
                    o.position = hit[POS_W-1:0];
                    model_take_out(hit);
                end
                else
                    o.status = ST_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        o.count = model_len[COUNT_W-1:0];
        return o;
    endfunction

    // queue one request and track what it does to the list
    task automatic add_req(logic [ACTION_W-1:0] act, int idx,
                           logic signed [DATA_W-1:0] val, bit drain = 1'b0);
        queued_req_t q;
        int          len;
        int          hit;
        q.word.action     = act;
        q.word.index      = idx[INDEX_W-1:0];
        q.word.value      = val;
        q.hold_for_drain  = drain;
        requests_to_send.push_back(q);
        total_reqs++;
        idx = int'(q.word.index);
        len = stim_list.size();
        hit = -1;
        case (act)
            ACT_APPEND:
                if (len < CAPACITY)
                    stim_list.push_back(val);
            ACT_INSERT:
                if (idx <= len && len < CAPACITY)
                    stim_list.insert(idx, val);
            ACT_REMOVE_AT:
                if (idx < len)
                    stim_list.delete(idx);
            ACT_REMOVE_VAL:
            begin
                for (int k = 0; k < len && hit < 0; k++)
                begin
                    if (stim_list[k] == val)
                        hit = k;
                end
                if (hit >= 0)
                    stim_list.delete(hit);
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return $urandom_range(0, 6) - 3;    // small pool, so duplicates occur
        else if (roll == 5)
        begin
            case ($urandom_range(0, 3))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // driver: hold a word until taken, then send the next one or idle
    always @(negedge clk)
    begin : driver
        queued_req_t nxt;
        logic        go;
        req_t        word;
        go   = start && !hs_seen;
        word = req;
        if (!rst_n)
            go = 1'b0;
        else if (!go)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (requests_to_send.size() > 0 &&
                     !(requests_to_send[0].hold_for_drain && list_results_due.size() != 0))
            begin
                nxt  = requests_to_send.pop_front();
                word = nxt.word;
                go   = 1'b1;
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(40, 80);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 8);
                    end
                end
                else
                    burst_left--;
            end
        end
        start <= go;
        req   <= word;
    end

    // monitor: check result words, then predict a newly accepted request
    always @(posedge clk)
    begin : monitor
        rsp_t due;
        if (!rst_n)
            hs_seen = 1'b0;
        else
        begin
            if (done)
            begin
                if (list_results_due.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got data_out %0d",
                             $time, rsp.data_out);
                    errors++;
                end
                else
                begin
                    due = list_results_due.pop_front();
                    if (rsp.data_out !== due.data_out)
                    begin
                        $display("%0t: data_out expected %0d got %0d",
                                 $time, due.data_out, rsp.data_out);
                        errors++;
                    end
                    if (rsp.position !== due.position)
                    begin
                        $display("%0t: position expected %0d got %0d",
                                 $time, due.position, rsp.position);
                        errors++;
                    end
                    if (rsp.status !== due.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, due.status, rsp.status);
                        errors++;
                    end
                    if (rsp.count !== due.count)
                    begin
                        $display("%0t: count expected %0d got %0d",
                                 $time, due.count, rsp.count);
                        errors++;
                    end
                end
            end
            hs_seen = start && !busy;
            if (hs_seen)
            begin
                list_results_due.push_back(list_apply(req));
                accepted_reqs++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("indexed_array_list: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int  len;
        int  roll;
        bit  grow;
        logic [ACTION_W-1:0] act;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        grow  = 1'b1;

        // directed opener: empty list, range edges, unknown actions, full list
        add_req(ACT_READ, 0, 0);
        add_req(ACT_REMOVE_AT, 0, 0);
        add_req(ACT_REMOVE_VAL, 0, 5);
        add_req(ACT_INSERT, 1, 9);
        add_req(ACT_INSERT, 0, WORD_MIN);
        add_req(ACT_APPEND, 0, WORD_MAX);
        add_req(ACT_INSERT, 2, -1);
        add_req(ACT_INSERT, 31, 7);
        add_req(ACT_READ, 31, 0);
        add_req(ACT_REMOVE_AT, 31, 0);
        add_req(ACT_SPARE_FIRST, 0, 1);
        add_req(ACT_SPARE_LAST, 31, -1);
        add_req(ACT_REMOVE_VAL, 0, WORD_MAX);
        for (int k = 0; k < CAPACITY - 2; k++)
        begin
            add_req(ACT_APPEND, 0, k - 3);
        end
        add_req(ACT_APPEND, 0, 3);
        add_req(ACT_INSERT, 17, 3);
        add_req(ACT_INSERT, 16, 3);
        add_req(ACT_REMOVE_AT, 15, 0);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            len = stim_list.size();
            if (len == 0)
                grow = 1'b1;
            else if (len == CAPACITY && grow && $urandom_range(0, 3) == 0)
                grow = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                // noise: spare actions or any action with a wild index
                if ($urandom_range(0, 1) == 0)
                    act = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
                else
                    act = ACTION_W'($urandom_range(ACT_READ, ACT_REMOVE_VAL));
                add_req(act, $urandom_range(0, 31), $urandom, n % 300 == 0);
            end
            else if (roll < 15)
                add_req(ACT_READ, (len > 0) ? $urandom_range(0, len - 1) : 0, $urandom,
                        n % 300 == 0);
            else if (roll < (grow ? 65 : 35))
            begin
                if ($urandom_range(0, 1) == 0)
                    add_req(ACT_APPEND, $urandom_range(0, 31), pick_value(), n % 300 == 0);
                else
                    add_req(ACT_INSERT, $urandom_range(0, len), pick_value(), n % 300 == 0);
            end
            else if ($urandom_range(0, 1) == 0)
                add_req(ACT_REMOVE_AT, (len > 0) ? $urandom_range(0, len - 1) : 0, $urandom,
                        n % 300 == 0);
            else if (len > 0 && $urandom_range(0, 9) < 7)
                add_req(ACT_REMOVE_VAL, $urandom_range(0, 31),
                        stim_list[$urandom_range(0, len - 1)], n % 300 == 0);
            else
                add_req(ACT_REMOVE_VAL, $urandom_range(0, 31), pick_value(), n % 300 == 0);
        end

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        while (accepted_reqs < total_reqs || list_results_due.size() != 0)
            @(negedge clk);
        // let any stray result show up before the verdict
        repeat (2 * CAPACITY + 8) @(negedge clk);
        if (errors == 0)
            $display("indexed_array_list: match");
        else
            $display("indexed_array_list: mismatch");
        $finish;
    end

endmodule
